@@ design/bmp8_palette_gray_renderer_assert.svh @@
// ---------------------------------------------------------------------------
// bmp8 assertion macros
// Reset-qualified concurrent assertion helpers for the bitmap gray renderer.
// ---------------------------------------------------------------------------
`ifndef BMP8_PALETTE_GRAY_RENDERER_ASSERT_SVH
`define BMP8_PALETTE_GRAY_RENDERER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMP8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMP8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/bmp8_pkg.sv @@
// ---------------------------------------------------------------------------
// bmp8_pkg
// Shared constants, codes and types of the bitmap palette gray renderer.
// ---------------------------------------------------------------------------
package bmp8_pkg;

	localparam int MAX_DIM         = 4096;
	localparam int PALETTE_ENTRIES = 256;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 32;
	localparam int HALF_W     = 16;
	localparam int COORD_W    = 13;
	localparam int ORIGIN_W   = 12;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int PAL_ADDR_W = $clog2(PALETTE_ENTRIES);
	localparam int REL_W      = $clog2(4 * PALETTE_ENTRIES);
	localparam int GRAY_SUM_W = 24;

	// Header field positions (all inside the first 32 bytes)
	localparam logic [4:0] POS_OFFSET = 5'd10;
	localparam logic [4:0] POS_WIDTH  = 5'd18;
	localparam logic [4:0] POS_HEIGHT = 5'd22;
	localparam logic [4:0] POS_BPP    = 5'd28;

	localparam logic [WORD_W-1:0] POS_PALETTE = 32'd54;
	localparam logic [WORD_W-1:0] PALETTE_END = WORD_W'(54 + 4 * PALETTE_ENTRIES);
	localparam logic [WORD_W-1:0] DIM_LIMIT   = WORD_W'(MAX_DIM);
	localparam logic [HALF_W-1:0] BPP_INDEXED = 16'd8;

	// Luma weights 0.299, 0.587 and 0.114 in 16-bit fixed point
	localparam logic [HALF_W-1:0]     WEIGHT_R        = 16'd19595;
	localparam logic [HALF_W-1:0]     WEIGHT_G        = 16'd38470;
	localparam logic [HALF_W-1:0]     WEIGHT_B        = 16'd7471;
	localparam logic [GRAY_SUM_W-1:0] ROUND_HALF_DOWN = 24'd32767;

	localparam logic [STATUS_W-1:0] STATUS_PIXEL     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD_DEPTH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE  = 2'd2;

	// Queue between parser and executor; depth must be a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X = 1'b0,
		REG_ORIGIN_Y = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_PAL = 2'd0,
		CMD_PIX = 2'd1,
		CMD_ERR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t               kind;
		logic [PAL_ADDR_W-1:0]   addr;
		logic [BYTE_W-1:0]       blue;
		logic [BYTE_W-1:0]       green;
		logic [BYTE_W-1:0]       red;
		logic [COORD_W-1:0]      pixel_x;
		logic [COORD_W-1:0]      pixel_y;
		logic [STATUS_W-1:0]     status;
		logic                    last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_stat_t;

endpackage

@@ design/bmp8_if.sv @@
// ---------------------------------------------------------------------------
// bmp8 channel interfaces
// Valid/ready channels for file bytes, rendered pixels and register writes.
// ---------------------------------------------------------------------------
interface bmp8_byte_if import bmp8_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] file_byte;
	logic              start_of_file;

	modport source (output valid, output file_byte, output start_of_file, input ready);
	modport sink   (input valid, input file_byte, input start_of_file, output ready);
endinterface

interface bmp8_pix_if import bmp8_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [COORD_W-1:0]  pixel_x;
	logic [COORD_W-1:0]  pixel_y;
	logic [BYTE_W-1:0]   gray_level;
	logic [STATUS_W-1:0] status;
	logic                last;

	modport source (output valid, output pixel_x, output pixel_y, output gray_level,
		output status, output last, input ready);
	modport sink   (input valid, input pixel_x, input pixel_y, input gray_level,
		input status, input last, output ready);
endinterface

interface bmp8_cfg_if import bmp8_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [ORIGIN_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/bmp8_front.sv @@
// ---------------------------------------------------------------------------
// bmp8_front
// Byte parser: tracks the file position, collects the header, and turns
// palette, pixel and error bytes into commands for the executor queue.
// ---------------------------------------------------------------------------
module bmp8_front import bmp8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bmp8_byte_if.sink  byte_in,
	bmp8_cfg_if.sink   cfg,
	input  fifo_stat_t fifo_stat,
	output logic       push,
	output cmd_t       cmd
);

	logic [WORD_W-1:0]   pos_q, offset_q, width_q, height_q;
	logic [BYTE_W-1:0]   bpp_lo_q, blue_q, green_q;
	logic [COORD_W-1:0]  row_q, col_q;
	logic                done_q;
	logic [ORIGIN_W-1:0] origin_x_q, origin_y_q;

	logic [WORD_W-1:0]   pos, offset_c, width_c, height_c;
	logic [BYTE_W-1:0]   bpp_lo_c, blue_c, green_c;
	logic [COORD_W-1:0]  row_c, col_c;
	logic                done_c;

	logic [WORD_W-1:0]   pos_n, offset_n, width_n, height_n;
	logic [BYTE_W-1:0]   bpp_lo_n, blue_n, green_n;
	logic [COORD_W-1:0]  row_n, col_n;
	logic                done_n;

	logic                accept;
	logic                gen;
	logic [BYTE_W-1:0]   b;
	logic [1:0]          lane;
	logic [REL_W-1:0]    rel;
	logic [WORD_W-1:0]   rel_full;
	logic [HALF_W-1:0]   bpp_full;
	logic [COORD_W-1:0]  stride, col_inc;
	logic                is_last;

	assign byte_in.ready = !fifo_stat.full;
	assign accept        = byte_in.valid && byte_in.ready;
	assign push          = accept && gen;
	assign cfg.ready     = 1'b1;

	always_comb begin
		b = byte_in.file_byte;
		// A start mark clears the parse state before this byte is taken
		if (byte_in.start_of_file) begin
			pos      = '0;
			offset_c = '0;
			width_c  = '0;
			height_c = '0;
			bpp_lo_c = '0;
			blue_c   = '0;
			green_c  = '0;
			row_c    = '0;
			col_c    = '0;
			done_c   = 1'b0;
		end else begin
			pos      = pos_q;
			offset_c = offset_q;
			width_c  = width_q;
			height_c = height_q;
			bpp_lo_c = bpp_lo_q;
			blue_c   = blue_q;
			green_c  = green_q;
			row_c    = row_q;
			col_c    = col_q;
			done_c   = done_q;
		end

		pos_n    = (&pos) ? pos : pos + 32'd1;
		offset_n = offset_c;
		width_n  = width_c;
		height_n = height_c;
		bpp_lo_n = bpp_lo_c;
		blue_n   = blue_c;
		green_n  = green_c;
		row_n    = row_c;
		col_n    = col_c;
		done_n   = done_c;

		gen      = 1'b0;
		cmd      = '0;
		cmd.kind = CMD_PAL;

		lane     = '0;
		rel_full = pos - POS_PALETTE;
		rel      = rel_full[REL_W-1:0];
		bpp_full = {b, bpp_lo_c};
		stride   = (width_c[COORD_W-1:0] + 13'd3) & ~13'd3;
		col_inc  = col_c + 13'd1;
		is_last  = (({{(WORD_W-COORD_W){1'b0}}, row_c} + 32'd1) == height_c) &&
			(({{(WORD_W-COORD_W){1'b0}}, col_c} + 32'd1) == width_c);

		if (!done_c) begin
			if (pos[WORD_W-1:5] == '0) begin
				if (pos[4:0] >= POS_OFFSET && pos[4:0] < POS_OFFSET + 5'd4) begin
					lane = pos[1:0] - POS_OFFSET[1:0];
					offset_n[{lane, 3'b000} +: BYTE_W] = b;
				end else if (pos[4:0] >= POS_WIDTH && pos[4:0] < POS_WIDTH + 5'd4) begin
					lane = pos[1:0] - POS_WIDTH[1:0];
					width_n[{lane, 3'b000} +: BYTE_W] = b;
				end else if (pos[4:0] >= POS_HEIGHT && pos[4:0] < POS_HEIGHT + 5'd4) begin
					lane = pos[1:0] - POS_HEIGHT[1:0];
					height_n[{lane, 3'b000} +: BYTE_W] = b;
				end else if (pos[4:0] == POS_BPP) begin
					bpp_lo_n = b;
				end else if (pos[4:0] == POS_BPP + 5'd1) begin
					if (bpp_full != BPP_INDEXED) begin
						gen        = 1'b1;
						cmd.kind   = CMD_ERR;
						cmd.status = STATUS_BAD_DEPTH;
						cmd.last   = 1'b1;
						done_n     = 1'b1;
					end else if (offset_c < PALETTE_END || width_c > DIM_LIMIT ||
						height_c > DIM_LIMIT) begin
						gen        = 1'b1;
						cmd.kind   = CMD_ERR;
						cmd.status = STATUS_BAD_SIZE;
						cmd.last   = 1'b1;
						done_n     = 1'b1;
					end else if (width_c == '0 || height_c == '0) begin
						done_n = 1'b1;
					end
				end
			end else if (pos >= POS_PALETTE && pos < PALETTE_END) begin
				// Entries are blue, green, red, unused; red completes the entry
				case (rel[1:0])
					2'd0: blue_n = b;
					2'd1: green_n = b;
					2'd2: begin
						gen       = 1'b1;
						cmd.kind  = CMD_PAL;
						cmd.addr  = rel[REL_W-1:2];
						cmd.blue  = blue_c;
						cmd.green = green_c;
						cmd.red   = b;
					end
					default: ;
				endcase
			end else if (pos >= PALETTE_END && pos >= offset_c) begin
				if ({{(WORD_W-COORD_W){1'b0}}, col_c} < width_c) begin
					gen         = 1'b1;
					cmd.kind    = CMD_PIX;
					cmd.addr    = b;
					cmd.pixel_x = {1'b0, origin_x_q} + col_c;
					cmd.pixel_y = {1'b0, origin_y_q} +
						(height_c[COORD_W-1:0] - 13'd1 - row_c);
					cmd.status  = STATUS_PIXEL;
					cmd.last    = is_last;
					if (is_last) begin
						done_n = 1'b1;
					end
				end
				// Columns beyond the width are row padding
				if (col_inc >= stride) begin
					col_n = '0;
					row_n = row_c + 13'd1;
				end else begin
					col_n = col_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			offset_q <= '0;
			width_q  <= '0;
			height_q <= '0;
			bpp_lo_q <= '0;
			blue_q   <= '0;
			green_q  <= '0;
			row_q    <= '0;
			col_q    <= '0;
			done_q   <= 1'b0;
		end else if (accept) begin
			pos_q    <= pos_n;
			offset_q <= offset_n;
			width_q  <= width_n;
			height_q <= height_n;
			bpp_lo_q <= bpp_lo_n;
			blue_q   <= blue_n;
			green_q  <= green_n;
			row_q    <= row_n;
			col_q    <= col_n;
			done_q   <= done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ORIGIN_X: origin_x_q <= cfg.data;
				REG_ORIGIN_Y: origin_y_q <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

@@ design/bmp8_fifo.sv @@
// ---------------------------------------------------------------------------
// bmp8_fifo
// Short command queue that decouples the parser from the executor.
// ---------------------------------------------------------------------------
`include "bmp8_palette_gray_renderer_assert.svh"

module bmp8_fifo import bmp8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       cmd_in,
	input  logic       pop,
	output cmd_t       head,
	output fifo_stat_t stat
);

	cmd_t                  slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign head           = slots_q[rd_ptr_q];
	assign stat.full      = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`BMP8_ASSERT_NOW(a_fifo_no_overflow, push, !stat.full, "command pushed into a full queue")
	`BMP8_ASSERT_NOW(a_fifo_no_underflow, pop, count_q != '0, "command popped from an empty queue")

endmodule

@@ design/bmp8_back.sv @@
// ---------------------------------------------------------------------------
// bmp8_back
// Executor: converts palette entries to gray and stores them, looks pixels
// up in the gray palette and drives the registered result channel.
// ---------------------------------------------------------------------------
`include "bmp8_palette_gray_renderer_assert.svh"

module bmp8_back import bmp8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  fifo_stat_t fifo_stat,
	output logic       pop,
	bmp8_pix_if.source pix_out
);

	logic [BYTE_W-1:0] pal_mem [PALETTE_ENTRIES];

	// Stage 1: products or palette read
	logic                  valid_s1;
	cmd_kind_t             kind_s1;
	logic [PAL_ADDR_W-1:0] addr_s1;
	logic [COORD_W-1:0]    x_s1, y_s1;
	logic [STATUS_W-1:0]   status_s1;
	logic                  last_s1;
	logic [GRAY_SUM_W-1:0] prod_r_s1, prod_g_s1, prod_b_s1;
	logic [BYTE_W-1:0]     rd_s1;

	// Stage 2: result register
	logic                  valid_s2;
	logic [COORD_W-1:0]    x_s2, y_s2;
	logic [BYTE_W-1:0]     gray_s2;
	logic [STATUS_W-1:0]   status_s2;
	logic                  last_s2;

	logic                  out_en, s1_retire, s1_free, s1_to_out, hazard;
	logic [GRAY_SUM_W-1:0] gray_sum;

	assign out_en    = !valid_s2 || pix_out.ready;
	assign s1_to_out = valid_s1 && (kind_s1 != CMD_PAL) && out_en;
	assign s1_retire = valid_s1 && ((kind_s1 == CMD_PAL) || out_en);
	assign s1_free   = !valid_s1 || s1_retire;
	// A pixel must not read the palette in the cycle an entry is being written
	assign hazard    = valid_s1 && (kind_s1 == CMD_PAL) && (head.kind == CMD_PIX);
	assign pop       = fifo_stat.not_empty && s1_free && !hazard;

	assign gray_sum  = prod_r_s1 + prod_g_s1 + prod_b_s1 + ROUND_HALF_DOWN;

	always_ff @(posedge clk) begin
		if (valid_s1 && kind_s1 == CMD_PAL) begin
			pal_mem[addr_s1] <= gray_sum[GRAY_SUM_W-1 -: BYTE_W];
		end
		if (pop) begin
			rd_s1 <= pal_mem[head.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1   <= head.kind;
			addr_s1   <= head.addr;
			x_s1      <= head.pixel_x;
			y_s1      <= head.pixel_y;
			status_s1 <= head.status;
			last_s1   <= head.last;
			prod_r_s1 <= GRAY_SUM_W'(WEIGHT_R) * GRAY_SUM_W'(head.red);
			prod_g_s1 <= GRAY_SUM_W'(WEIGHT_G) * GRAY_SUM_W'(head.green);
			prod_b_s1 <= GRAY_SUM_W'(WEIGHT_B) * GRAY_SUM_W'(head.blue);
		end
		if (s1_to_out) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			gray_s2   <= (kind_s1 == CMD_PIX) ? rd_s1 : '0;
			status_s2 <= status_s1;
			last_s2   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_retire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_to_out) begin
				valid_s2 <= 1'b1;
			end else if (pix_out.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign pix_out.valid      = valid_s2;
	assign pix_out.pixel_x    = x_s2;
	assign pix_out.pixel_y    = y_s2;
	assign pix_out.gray_level = gray_s2;
	assign pix_out.status     = status_s2;
	assign pix_out.last       = last_s2;

	`BMP8_ASSERT_NOW(a_err_is_last, valid_s2 && status_s2 != STATUS_PIXEL, last_s2 && gray_s2 == '0, "error result without last or with nonzero gray")
	`BMP8_ASSERT_NEXT(a_s1_holds, valid_s1 && kind_s1 != CMD_PAL && !out_en, valid_s1 && $stable(x_s1) && $stable(y_s1), "blocked result lost from stage one")
	`BMP8_ASSERT_NOW(a_no_read_during_write, pop && head.kind == CMD_PIX, !(valid_s1 && kind_s1 == CMD_PAL), "pixel read overlaps a palette write")

endmodule

@@ design/bmp8_palette_gray_renderer.sv @@
// ---------------------------------------------------------------------------
// bmp8_palette_gray_renderer
// Streams an 8-bit indexed bitmap file and emits gray pixels at screen
// positions, with one error result for an unsupported or malformed header.
// ---------------------------------------------------------------------------
// Usage:
// byte_in takes the file one byte per beat; start_of_file on a beat restarts
// parsing at byte 0 (after reset the parser already sits at byte 0).
// pix_out gives one beat per pixel in file order (rows bottom-up), or a
// single beat with status 1 or 2 for a rejected header; last marks the end.
// cfg writes origin_x (index 0) and origin_y (index 1); it is always ready
// and should only be used while the block is idle.
// Throughput is one byte per cycle while the command queue has room. On its
// way out a result is registered in the command queue, in the executor's
// palette read or multiply stage and in the output register. The first
// pixel after the palette may be held in the queue while the last palette
// entry is written into the gray table.
// When pix_out stalls, results wait in the output register, the executor
// and a four-entry command queue; byte_in drops ready once the queue fills.
// Reset clears the parser and both origins; the gray table is not cleared
// and is only valid once a file's palette has passed through.
// ---------------------------------------------------------------------------
module bmp8_palette_gray_renderer import bmp8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	bmp8_byte_if.sink  byte_in,
	bmp8_pix_if.source pix_out,
	bmp8_cfg_if.sink   cfg
);

	logic       push, pop;
	cmd_t       cmd, head;
	fifo_stat_t fifo_stat;

	bmp8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (byte_in),
		.cfg       (cfg),
		.fifo_stat (fifo_stat),
		.push      (push),
		.cmd       (cmd)
	);

	bmp8_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.stat   (fifo_stat)
	);

	bmp8_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.fifo_stat (fifo_stat),
		.pop       (pop),
		.pix_out   (pix_out)
	);

endmodule

@@ sim/bmp8_render_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bmp8_render_checker
// Watches the byte, pixel and register channels of the bitmap gray renderer.
// It parses the accepted file bytes with its own copy of the header, palette
// and raster state, and compares every pixel beat field by field, in order.
// ---------------------------------------------------------------------------
module bmp8_render_checker import bmp8_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	bmp8_byte_if  byte_ch,
	bmp8_pix_if   pix_ch,
	bmp8_cfg_if   cfg_ch,
	input  logic  drain_done,
	output int    pending,
	output int    fail_count,
	output int    beats_checked
);

	typedef struct packed {
		logic [COORD_W-1:0]  pixel_x;
		logic [COORD_W-1:0]  pixel_y;
		logic [BYTE_W-1:0]   gray_level;
		logic [STATUS_W-1:0] status;
		logic                last;
	} pix_beat_t;

	pix_beat_t expected_pixels[$];

	logic [ORIGIN_W-1:0] origin_x    = '0;
	logic [ORIGIN_W-1:0] origin_y    = '0;
	logic [WORD_W-1:0]   byte_pos    = '0;
	logic [WORD_W-1:0]   data_offset = '0;
	logic [WORD_W-1:0]   img_width   = '0;
	logic [WORD_W-1:0]   img_height  = '0;
	logic [HALF_W-1:0]   depth       = '0;
	logic [BYTE_W-1:0]   blue_hold   = '0;
	logic [BYTE_W-1:0]   green_hold  = '0;
	logic [COORD_W-1:0]  row_idx     = '0;
	logic [COORD_W-1:0]  col_idx     = '0;
	logic                file_done   = 1'b0;
	logic [BYTE_W-1:0]   gray_table [PALETTE_ENTRIES];
	int                  fails       = 0;
	int                  checked     = 0;
	bit                  leftover_checked = 1'b0;

	initial begin
		for (int i = 0; i < PALETTE_ENTRIES; i++) gray_table[i] = '0;
	end

	// Weighted sum in 16-bit fixed point; the offset makes exact halves round down.
	function automatic logic [BYTE_W-1:0] luma(input logic [BYTE_W-1:0] r,
		input logic [BYTE_W-1:0] g, input logic [BYTE_W-1:0] b);
		logic [WORD_W-1:0] sum;
		sum = WORD_W'(WEIGHT_R) * WORD_W'(r) + WORD_W'(WEIGHT_G) * WORD_W'(g)
			+ WORD_W'(WEIGHT_B) * WORD_W'(b) + WORD_W'(ROUND_HALF_DOWN);
		return sum[23:16];
	endfunction

	task automatic parse_file_byte(input logic [BYTE_W-1:0] b, input logic sof);
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] rel;
		logic [WORD_W-1:0] stride;
		pix_beat_t         beat;
		beat = '0;
		if (sof) begin
			byte_pos    = '0;
			data_offset = '0;
			img_width   = '0;
			img_height  = '0;
			depth       = '0;
			blue_hold   = '0;
			green_hold  = '0;
			row_idx     = '0;
			col_idx     = '0;
			file_done   = 1'b0;
		end
		pos = byte_pos;
		if (byte_pos != '1) byte_pos = byte_pos + 1;
		if (file_done) return;

		if (pos >= POS_OFFSET && pos < POS_OFFSET + 4) begin
			data_offset |= WORD_W'(b) << (8 * (pos - POS_OFFSET));
		end else if (pos >= POS_WIDTH && pos < POS_WIDTH + 4) begin
			img_width |= WORD_W'(b) << (8 * (pos - POS_WIDTH));
		end else if (pos >= POS_HEIGHT && pos < POS_HEIGHT + 4) begin
			img_height |= WORD_W'(b) << (8 * (pos - POS_HEIGHT));
		end else if (pos >= POS_BPP && pos < POS_BPP + 2) begin
			depth |= HALF_W'(b) << (8 * (pos - POS_BPP));
			if (pos == WORD_W'(POS_BPP) + 1) begin
				if (depth != BPP_INDEXED) begin
					beat.status = STATUS_BAD_DEPTH;
					beat.last   = 1'b1;
					expected_pixels.push_back(beat);
					file_done = 1'b1;
				end else if (data_offset < PALETTE_END || img_width > DIM_LIMIT
					|| img_height > DIM_LIMIT) begin
					beat.status = STATUS_BAD_SIZE;
					beat.last   = 1'b1;
					expected_pixels.push_back(beat);
					file_done = 1'b1;
				end else if (img_width == 0 || img_height == 0) begin
					file_done = 1'b1;
				end
			end
		end else if (pos >= POS_PALETTE && pos < PALETTE_END) begin
			// Entries are blue, green, red, unused; the gray level is stored on red.
			rel = pos - POS_PALETTE;
			case (rel[1:0])
				2'd0:    blue_hold = b;
				2'd1:    green_hold = b;
				2'd2:    gray_table[rel[2 +: PAL_ADDR_W]] = luma(b, green_hold, blue_hold);
				default: ;
			endcase
		end else if (pos >= PALETTE_END && pos >= data_offset) begin
			stride = ((img_width + 3) >> 2) << 2;
			if (WORD_W'(col_idx) < img_width) begin
				beat.pixel_x    = COORD_W'(WORD_W'(origin_x) + WORD_W'(col_idx));
				beat.pixel_y    = COORD_W'(WORD_W'(origin_y) + img_height - 1 - WORD_W'(row_idx));
				beat.gray_level = gray_table[b];
				beat.status     = STATUS_PIXEL;
				beat.last       = (WORD_W'(row_idx) + 1 == img_height)
					&& (WORD_W'(col_idx) + 1 == img_width);
				expected_pixels.push_back(beat);
				if (beat.last) file_done = 1'b1;
			end
			// Padding bytes advance the column without producing a beat.
			col_idx = col_idx + 1;
			if (WORD_W'(col_idx) >= stride) begin
				col_idx = '0;
				row_idx = row_idx + 1;
			end
		end
	endtask

	task automatic compare_field(input string name, input logic [COORD_W-1:0] want,
		input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_beat();
		pix_beat_t want;
		if (expected_pixels.size() == 0) begin
			$error("pixel beat with nothing expected: x %0d y %0d gray %0d status %0d last %0d",
				pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.gray_level, pix_ch.status, pix_ch.last);
			fails++;
			return;
		end
		want = expected_pixels.pop_front();
		checked++;
		compare_field("pixel_x", want.pixel_x, pix_ch.pixel_x);
		compare_field("pixel_y", want.pixel_y, pix_ch.pixel_y);
		compare_field("gray_level", COORD_W'(want.gray_level), COORD_W'(pix_ch.gray_level));
		compare_field("status", COORD_W'(want.status), COORD_W'(pix_ch.status));
		compare_field("last", COORD_W'(want.last), COORD_W'(pix_ch.last));
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_reg_t'(cfg_ch.index))
					REG_ORIGIN_X: origin_x = cfg_ch.data;
					REG_ORIGIN_Y: origin_y = cfg_ch.data;
					default:      ;
				endcase
			end
			if (pix_ch.valid && pix_ch.ready) check_beat();
			if (byte_ch.valid && byte_ch.ready)
				parse_file_byte(byte_ch.file_byte, byte_ch.start_of_file);
			if (drain_done && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (expected_pixels.size() != 0) begin
					$error("%0d expected pixel beats never arrived", expected_pixels.size());
					fails++;
				end
			end
		end
		pending       <= expected_pixels.size();
		fail_count    <= fails;
		beats_checked <= checked;
	end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Streams bitmap files into the gray renderer: rejected and empty headers,
// a complete image with a random palette, truncated and restarted files,
// headers at the largest dimensions and plain noise, under several handshake
// pacings and screen origins. A checker beside the block predicts the beats.
// ---------------------------------------------------------------------------
module tb_top;
	import bmp8_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int ITEM_TARGET   = 1650;
	localparam int MIN_FILES     = 8;

	typedef enum int {
		FILE_IMAGE,
		FILE_BROKEN,
		FILE_BAD_DEPTH,
		FILE_BAD_SIZE,
		FILE_EMPTY,
		FILE_NOISE,
		FILE_HUGE
	} file_kind_t;

	logic clk;
	logic arst_n;
	logic drain_done;
	int   pending;
	int   fail_count;
	int   beats_checked;
	int   cycle_count = 0;
	int   send_idle_pct;
	int   stall_pct;
	bit   hold_asked;
	int   items;
	int   files;
	int   images;
	int   origin_writes;
	int   pixel_start;

	logic [BYTE_W-1:0] file_q[$];

	bmp8_byte_if byte_ch ();
	bmp8_pix_if  pix_ch ();
	bmp8_cfg_if  cfg_ch ();

	bmp8_palette_gray_renderer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_ch),
		.pix_out (pix_ch),
		.cfg     (cfg_ch)
	);

	bmp8_render_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_ch       (byte_ch),
		.pix_ch        (pix_ch),
		.cfg_ch        (cfg_ch),
		.drain_done    (drain_done),
		.pending       (pending),
		.fail_count    (fail_count),
		.beats_checked (beats_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit.");
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off when the stimulus asks.
	initial begin : result_sink
		int hold_left;
		bit hold_taken;
		hold_left  = 0;
		hold_taken = 1'b0;
		pix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pix_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				pix_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic put_field(input int at, input logic [WORD_W-1:0] value, input int nbytes);
		for (int i = 0; i < nbytes; i++) file_q[at + i] = value[8*i +: 8];
	endtask

	task automatic make_header(input logic [WORD_W-1:0] offset, input logic [WORD_W-1:0] width,
		input logic [WORD_W-1:0] height, input logic [HALF_W-1:0] bpp);
		file_q.delete();
		pixel_start = -1;
		repeat (POS_PALETTE) file_q.push_back(BYTE_W'($urandom));
		put_field(POS_OFFSET, offset, 4);
		put_field(POS_WIDTH, width, 4);
		put_field(POS_HEIGHT, height, 4);
		put_field(POS_BPP, WORD_W'(bpp), 2);
	endtask

	task automatic trim_file(input int len);
		while (file_q.size() > len) void'(file_q.pop_back());
	endtask

	task automatic add_palette();
		logic [WORD_W-1:0] entry;
		for (int i = 0; i < PALETTE_ENTRIES; i++) begin
			case ($urandom_range(7))
				0:       entry = '0;
				1:       entry = '1;
				default: entry = $urandom;
			endcase
			for (int k = 0; k < 4; k++) file_q.push_back(entry[8*k +: 8]);
		end
	endtask

	task automatic add_pixels(input int width, input int height, input int max_bytes);
		int stride;
		stride = (width + 3) / 4 * 4;
		pixel_start = file_q.size();
		for (int n = 0; n < stride * height && n < max_bytes; n++)
			file_q.push_back(BYTE_W'($urandom));
	endtask

	task automatic make_file(input file_kind_t kind, input bit roomy);
		logic [WORD_W-1:0] offset;
		logic [WORD_W-1:0] width;
		logic [WORD_W-1:0] height;
		logic [HALF_W-1:0] bpp;
		int                gap;
		offset = PALETTE_END + $urandom_range(0, 9);
		width  = $urandom_range(1, MAX_DIM);
		height = $urandom_range(1, MAX_DIM);
		case (kind)
			FILE_IMAGE, FILE_BROKEN: begin
				width  = roomy ? 40 : $urandom_range(1, 12);
				height = roomy ? 8 : $urandom_range(1, 6);
				gap    = $urandom_range(0, 6);
				make_header(PALETTE_END + gap, width, height, BPP_INDEXED);
				add_palette();
				repeat (gap) file_q.push_back(BYTE_W'($urandom));
				add_pixels(width, height, MAX_DIM * MAX_DIM);
				if (kind == FILE_IMAGE) begin
					images++;
					repeat ($urandom_range(0, 3)) file_q.push_back(BYTE_W'($urandom));
				end else begin
					// Cut inside the header or a little way into the palette.
					case ($urandom_range(1))
						0:       trim_file($urandom_range(1, 40));
						default: trim_file($urandom_range(41, POS_PALETTE + 40));
					endcase
				end
			end
			FILE_BAD_DEPTH: begin
				case ($urandom_range(4))
					0:       bpp = '0;
					1:       bpp = 16'd24;
					2:       bpp = '1;
					3:       bpp = 16'h0108;
					default: begin
						bpp = HALF_W'($urandom);
						if (bpp == BPP_INDEXED) bpp = 16'd4;
					end
				endcase
				// Size fields are random too: the depth check takes priority.
				make_header($urandom, $urandom, $urandom, bpp);
				trim_file(POS_BPP + 2 + $urandom_range(0, 6));
			end
			FILE_BAD_SIZE: begin
				case ($urandom_range(4))
					0:       offset = PALETTE_END - 1;
					1:       offset = $urandom_range(0, PALETTE_END - 1);
					2:       width = MAX_DIM + 1;
					3:       width = $urandom_range(MAX_DIM + 1, 32'hFFFF_FFFF);
					default: height = -$urandom_range(1, MAX_DIM);
				endcase
				make_header(offset, width, height, BPP_INDEXED);
				trim_file(POS_BPP + 2 + $urandom_range(0, 6));
			end
			FILE_EMPTY: begin
				if ($urandom_range(1)) width = '0;
				else height = '0;
				make_header(offset, width, height, BPP_INDEXED);
				trim_file(POS_BPP + 2 + $urandom_range(0, 24));
			end
			FILE_NOISE: begin
				file_q.delete();
				pixel_start = -1;
				repeat ($urandom_range(1, 48)) file_q.push_back(BYTE_W'($urandom));
			end
			default: begin
				case ($urandom_range(2))
					0:       width = MAX_DIM;
					1:       height = MAX_DIM;
					default: begin
						width  = MAX_DIM;
						height = MAX_DIM;
					end
				endcase
				gap = $urandom_range(0, 3);
				// The largest sizes pass the check; the file stops soon after the header.
				make_header(PALETTE_END + gap, width, height, BPP_INDEXED);
				trim_file(POS_BPP + 2 + $urandom_range(0, 24));
			end
		endcase
	endtask

	// Offers one byte, after a random gap, and returns on the edge it is taken.
	task automatic send_byte(input logic [BYTE_W-1:0] value, input logic sof);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid         <= 1'b1;
		byte_ch.file_byte     <= value;
		byte_ch.start_of_file <= sof;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		items++;
	endtask

	task automatic stream_file(input bit mark_start, input bit squeeze);
		for (int i = 0; i < file_q.size(); i++) begin
			if (squeeze && i == pixel_start) hold_asked = 1'b1;
			send_byte(file_q[i], mark_start && i == 0);
		end
		files++;
	endtask

	// Waits until every expected beat is out and the block has gone quiet.
	task automatic drain();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [ORIGIN_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		origin_writes++;
	endtask

	task automatic set_origins(input logic [ORIGIN_W-1:0] ox, input logic [ORIGIN_W-1:0] oy);
		drain();
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : stimulus
		file_kind_t          kind;
		int                  phase;
		int                  idle_plan [4];
		int                  stall_plan [4];
		logic [ORIGIN_W-1:0] corner_x [4];
		logic [ORIGIN_W-1:0] corner_y [4];
		idle_plan  = '{0, 69, 0, 25};
		stall_plan = '{0, 0, 69, 25};
		corner_x   = '{12'hFFF, 12'h000, 12'hFFF, 12'h000};
		corner_y   = '{12'hFFF, 12'hFFF, 12'h000, 12'h000};
		corner_x[3] = $urandom_range(0, 4095);
		corner_y[3] = $urandom_range(0, 4095);

		byte_ch.valid         = 1'b0;
		byte_ch.file_byte     = '0;
		byte_ch.start_of_file = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_ORIGIN_X;
		cfg_ch.data           = '0;
		drain_done            = 1'b0;
		send_idle_pct         = 0;
		stall_pct             = 0;
		hold_asked            = 1'b0;
		items                 = 0;
		files                 = 0;
		images                = 0;
		origin_writes         = 0;
		pixel_start           = -1;
		arst_n                = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The first file carries no start mark: the parser must already sit at byte 0.
		make_header(PALETTE_END, 32'd3, 32'd2, 16'd16);
		trim_file(POS_BPP + 2);
		stream_file(1'b0, 1'b0);
		// Offset one short of the palette end, oversize width, top-down height.
		make_header(PALETTE_END - 1, 32'd3, 32'd2, BPP_INDEXED);
		trim_file(POS_BPP + 2);
		stream_file(1'b1, 1'b0);
		make_header(PALETTE_END, MAX_DIM + 1, 32'd2, BPP_INDEXED);
		trim_file(POS_BPP + 2);
		stream_file(1'b1, 1'b0);
		make_header(PALETTE_END, 32'd3, 32'hFFFF_FFFF, BPP_INDEXED);
		trim_file(POS_BPP + 2);
		stream_file(1'b1, 1'b0);
		// A zero width is accepted but draws nothing; the trailing bytes are ignored.
		make_header(PALETTE_END, 32'd0, 32'd5, BPP_INDEXED);
		trim_file(POS_BPP + 6);
		stream_file(1'b1, 1'b0);

		for (int n = 0; n < MIN_FILES || items < ITEM_TARGET; n++) begin
			phase         = n % 4;
			send_idle_pct = idle_plan[phase];
			stall_pct     = stall_plan[phase];
			if (n % 2 == 0) begin
				if (n < 8)
					set_origins(corner_x[n / 2], corner_y[n / 2]);
				else
					set_origins($urandom_range(0, 4095), $urandom_range(0, 4095));
			end
			if (n == 0) begin
				// The complete image is larger and gets the long hold-off on its pixel data.
				make_file(FILE_IMAGE, 1'b1);
				stream_file(1'b1, 1'b1);
			end else begin
				kind = file_kind_t'($urandom_range(FILE_BROKEN, FILE_HUGE));
				if (kind == FILE_HUGE && $urandom_range(2) != 0) kind = FILE_BROKEN;
				make_file(kind, 1'b0);
				// Now and then the start mark is left off, so the bytes run on as trailing junk.
				stream_file($urandom_range(15) != 0, 1'b0);
			end
		end

		drain();
		drain_done <= 1'b1;
		repeat (2) @(posedge clk);
		$display("Streamed %0d file bytes in %0d files, %0d of them complete images.",
			items, files, images);
		$display("Checked %0d result beats over four pacings and %0d origin register writes.",
			beats_checked, origin_writes);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+design
design/bmp8_pkg.sv
design/bmp8_if.sv
design/bmp8_front.sv
design/bmp8_fifo.sv
design/bmp8_back.sv
design/bmp8_palette_gray_renderer.sv
sim/bmp8_render_checker.sv
sim/tb_top.sv
